### hdl/array_linked_list_free_list_macros.svh
// Assertion macros shared by the linked-list block
`ifndef ARRAY_LINKED_LIST_FREE_LIST_MACROS_SVH
`define ARRAY_LINKED_LIST_FREE_LIST_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ALL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ALL_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hdl/all_pkg.sv
// Package: request and status codes, the default node count and the controller state type of the linked-list block
package all_pkg;
    localparam int NODES_DEF = 256;

    localparam logic [3:0] REQ_INS_FRONT = 4'd0;
    localparam logic [3:0] REQ_INS_REAR  = 4'd1;
    localparam logic [3:0] REQ_RM_FRONT  = 4'd2;
    localparam logic [3:0] REQ_RM_REAR   = 4'd3;
    localparam logic [3:0] REQ_RM_CUR    = 4'd4;
    localparam logic [3:0] REQ_CLEAR     = 4'd5;
    localparam logic [3:0] REQ_SEARCH    = 4'd6;
    localparam logic [3:0] REQ_RETRIEVE  = 4'd7;
    localparam logic [3:0] REQ_PURGE     = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOCUR    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE_RD,      // wait for free-link read
        S_INS_WRITE,
        S_WALK_RD,      // issue link read of walk pointer
        S_WALK_WAIT,    // link data returns
        S_RM_FRONT_RD,
        S_RM_FRONT_WAIT,
        S_RM_CUR_RD,
        S_RM_CUR_WAIT,
        S_SEARCH_RD,
        S_SEARCH_WAIT,
        S_PURGE_REF_RD,
        S_PURGE_REF_WAIT,
        S_PURGE_NXT_RD,
        S_PURGE_NXT_WAIT,
        S_PURGE_ADV_RD,
        S_PURGE_ADV_WAIT,
        S_VIEW_RD,
        S_VIEW_WAIT,
        S_OUT
    } state_t;
endpackage

### hdl/all_ram.sv
// Generic single-port synchronous RAM with registered read
module all_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/all_ctrl.sv
// Sequencer: drives the node store one access at a time for each request, walking the list where needed
`include "array_linked_list_free_list_macros.svh"
module all_ctrl import all_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmp_payload,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               req_type,
    input  logic [31:0]              key,
    input  logic [63:0]              payload,
    input  logic [7:0]               position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic [7:0]               found_index,
    output logic                     current_valid,
    output logic [7:0]               current_index,
    output logic [31:0]              current_key,
    output logic [63:0]              current_payload,
    // memory side
    output logic [$clog2(NODES)-1:0] n_addr,
    output logic                     n_we_data,
    output logic                     n_we_link,
    output logic [31:0]              n_wkey,
    output logic [63:0]              n_wpay,
    output logic [$clog2(NODES):0]   n_wlink,
    input  logic [31:0]              n_rkey,
    input  logic [63:0]              n_rpay,
    input  logic [$clog2(NODES):0]   n_rlink,
    output logic [$clog2(NODES)-1:0] f_addr,
    output logic                     f_we,
    output logic [$clog2(NODES):0]   f_wlink,
    input  logic [$clog2(NODES):0]   f_rlink
);
    localparam int AW = $clog2(NODES);
    localparam logic [AW:0] NIL = (AW+1)'(NODES);
    localparam logic [AW:0] LAST = (AW+1)'(NODES - 1);

    state_t state_reg, state_next;
    logic [AW:0] head_reg, head_next, cur_reg, cur_next;
    logic [AW:0] fhead_reg, fhead_next, hw_reg, hw_next;
    logic [AW:0] q_reg, q_next, pre_reg, pre_next, s_reg, s_next;
    logic [AW:0] slot_reg, slot_next;
    logic [3:0]  req_reg, req_next;
    logic [31:0] key_reg, key_next, rkey_reg, rkey_next;
    logic [63:0] pay_reg, pay_next, rpay_reg, rpay_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [2:0]  st_reg, st_next;
    logic [7:0]  found_reg, found_next;
    logic        clr_reg, clr_next;

    function automatic logic is_slot(input logic [AW:0] s);
        return s < NIL;
    endfunction

    // next state and datapath registers
    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg; cur_next = cur_reg; fhead_next = fhead_reg;
        hw_next = hw_reg; q_next = q_reg; pre_next = pre_reg; s_next = s_reg;
        slot_next = slot_reg; req_next = req_reg; key_next = key_reg;
        pay_next = pay_reg; pos_next = pos_reg; cnt_next = cnt_reg;
        st_next = st_reg; found_next = found_reg; clr_next = clr_reg;
        rkey_next = rkey_reg; rpay_next = rpay_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type; key_next = key; pay_next = payload;
                    pos_next = position; st_next = ST_OK; found_next = '0;
                    cnt_next = '0; clr_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_VIEW_RD;
                unique case (req_reg)
                    REQ_INS_FRONT, REQ_INS_REAR:
                    begin
                        if (is_slot(fhead_reg))
                        begin
                            slot_next = fhead_reg;
                            state_next = S_TAKE_RD;
                        end
                        else if (!is_slot(hw_reg) || hw_reg != LAST)
                        begin
                            slot_next = is_slot(hw_reg) ? hw_reg + 1'b1 : '0;
                            hw_next = is_slot(hw_reg) ? hw_reg + 1'b1 : '0;
                            state_next = S_INS_WRITE;
                        end
                        else
                        begin
                            st_next = ST_FULL;
                        end
                    end
                    REQ_RM_FRONT, REQ_CLEAR:
                    begin
                        clr_next = (req_reg == REQ_CLEAR);
                        if (is_slot(head_reg)) state_next = S_RM_FRONT_RD;
                        else if (req_reg == REQ_RM_FRONT) st_next = ST_EMPTY;
                        else cur_next = NIL;
                    end
                    REQ_RM_REAR:
                    begin
                        if (!is_slot(head_reg)) st_next = ST_EMPTY;
                        else
                        begin
                            pre_next = NIL; q_next = head_reg;
                            state_next = S_WALK_RD;
                        end
                    end
                    REQ_RM_CUR:
                    begin
                        if (!is_slot(head_reg)) st_next = ST_EMPTY;
                        else if (!is_slot(cur_reg)) st_next = ST_NOCUR;
                        else if (cur_reg == head_reg) state_next = S_RM_FRONT_RD;
                        else
                        begin
                            q_next = head_reg;
                            state_next = S_RM_CUR_RD;
                        end
                    end
                    REQ_SEARCH, REQ_RETRIEVE:
                    begin
                        if (!is_slot(head_reg)) st_next = ST_EMPTY;
                        else
                        begin
                            q_next = head_reg;
                            state_next = S_SEARCH_RD;
                        end
                    end
                    REQ_PURGE:
                    begin
                        s_next = head_reg;
                        if (is_slot(head_reg)) state_next = S_PURGE_REF_RD;
                        else cur_next = head_reg;
                    end
                    default: ;
                endcase
            end
            S_TAKE_RD:
            begin
                state_next = S_INS_WRITE;
            end
            S_INS_WRITE:
            begin
                if (req_reg == REQ_INS_FRONT && is_slot(fhead_reg) &&
                    fhead_reg == slot_reg)
                    fhead_next = f_rlink;
                else if (is_slot(fhead_reg) && fhead_reg == slot_reg)
                    fhead_next = f_rlink;
                cur_next = slot_reg;
                if (req_reg == REQ_INS_FRONT || !is_slot(head_reg))
                begin
                    head_next = slot_reg;
                    state_next = S_VIEW_RD;
                end
                else
                begin
                    q_next = head_reg; pre_next = NIL;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_WAIT;
            end
            S_WALK_WAIT:
            begin
                if (is_slot(n_rlink))
                begin
                    pre_next = q_reg; q_next = n_rlink;
                    state_next = S_WALK_RD;
                end
                else if (req_reg == REQ_INS_REAR)
                begin
                    state_next = S_VIEW_RD; // link q -> slot written here
                end
                else if (!is_slot(pre_reg))
                begin
                    state_next = S_RM_FRONT_RD;
                end
                else
                begin
                    // pre becomes last, q freed
                    fhead_next = q_reg;
                    cur_next = pre_reg;
                    state_next = S_VIEW_RD;
                end
            end
            S_RM_FRONT_RD:
            begin
                state_next = S_RM_FRONT_WAIT;
            end
            S_RM_FRONT_WAIT:
            begin
                fhead_next = head_reg;
                head_next = n_rlink;
                cur_next = n_rlink;
                if (clr_reg && is_slot(n_rlink)) state_next = S_RM_FRONT_RD;
                else
                begin
                    if (clr_reg) cur_next = NIL;
                    state_next = S_VIEW_RD;
                end
            end
            S_RM_CUR_RD:
            begin
                state_next = S_RM_CUR_WAIT;
            end
            S_RM_CUR_WAIT:
            begin
                if (n_rlink == cur_reg)
                begin
                    pre_next = q_reg; q_next = cur_reg;
                    state_next = S_PURGE_NXT_RD; // reuse unlink path
                    clr_next = 1'b1;
                end
                else if (is_slot(n_rlink))
                begin
                    q_next = n_rlink;
                    state_next = S_RM_CUR_RD;
                end
                else
                begin
                    st_next = ST_NOCUR;
                    state_next = S_VIEW_RD;
                end
            end
            S_SEARCH_RD:
            begin
                state_next = S_SEARCH_WAIT;
            end
            S_SEARCH_WAIT:
            begin
                if ((req_reg == REQ_SEARCH &&
                     (cmp_payload ? n_rpay == pay_reg : n_rkey == key_reg)) ||
                    (req_reg == REQ_RETRIEVE && cnt_reg == pos_reg))
                begin
                    found_next = 8'(q_reg);
                    cur_next = q_reg;
                    state_next = S_VIEW_RD;
                end
                else if (is_slot(n_rlink))
                begin
                    q_next = n_rlink;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_SEARCH_RD;
                end
                else
                begin
                    st_next = ST_NOTFOUND;
                    state_next = S_VIEW_RD;
                end
            end
            S_PURGE_REF_RD:
            begin
                state_next = S_PURGE_REF_WAIT;
            end
            S_PURGE_REF_WAIT:
            begin
                rkey_next = n_rkey; rpay_next = n_rpay;
                pre_next = s_reg; q_next = n_rlink;
                if (is_slot(n_rlink)) state_next = S_PURGE_NXT_RD;
                else
                begin
                    cur_next = head_reg;
                    state_next = S_VIEW_RD;
                end
            end
            S_PURGE_NXT_RD:
            begin
                state_next = S_PURGE_NXT_WAIT;
            end
            S_PURGE_NXT_WAIT:
            begin
                if (clr_reg)
                begin
                    // remove-current unlink: pre.link <= q.link, free q
                    fhead_next = q_reg;
                    cur_next = pre_reg;
                    state_next = S_VIEW_RD;
                end
                else if (cmp_payload ? n_rpay == rpay_reg : n_rkey == rkey_reg)
                begin
                    fhead_next = q_reg;
                    q_next = n_rlink;
                    state_next = S_PURGE_ADV_RD;
                end
                else
                begin
                    pre_next = q_reg; q_next = n_rlink;
                    state_next = S_PURGE_ADV_RD;
                end
            end
            S_PURGE_ADV_RD:
            begin
                state_next = S_PURGE_ADV_WAIT;
            end
            S_PURGE_ADV_WAIT:
            begin
                // q_reg is next candidate or null
                if (is_slot(q_reg)) state_next = S_PURGE_NXT_RD;
                else
                begin
                    s_next = n_rlink;
                    if (is_slot(n_rlink)) state_next = S_PURGE_REF_RD;
                    else
                    begin
                        cur_next = head_reg;
                        state_next = S_VIEW_RD;
                    end
                end
            end
            S_VIEW_RD:
            begin
                state_next = S_VIEW_WAIT;
            end
            S_VIEW_WAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory addressing and writes
    always_comb
    begin
        n_addr = '0; n_we_data = 1'b0; n_we_link = 1'b0;
        n_wkey = key_reg; n_wpay = pay_reg; n_wlink = NIL;
        f_addr = '0; f_we = 1'b0; f_wlink = fhead_reg;
        unique case (state_reg)
            S_DISPATCH:
            begin
                f_addr = fhead_reg[AW-1:0];
            end
            S_TAKE_RD:
            begin
                f_addr = fhead_reg[AW-1:0];
            end
            S_INS_WRITE:
            begin
                n_addr = slot_reg[AW-1:0];
                n_we_data = 1'b1; n_we_link = 1'b1;
                n_wlink = (req_reg == REQ_INS_FRONT) ? head_reg : NIL;
            end
            S_WALK_RD, S_RM_CUR_RD, S_SEARCH_RD, S_PURGE_NXT_RD:
            begin
                n_addr = q_reg[AW-1:0];
            end
            S_WALK_WAIT:
            begin
                n_addr = q_reg[AW-1:0];
                if (!is_slot(n_rlink) && req_reg == REQ_INS_REAR)
                begin
                    n_addr = q_reg[AW-1:0]; n_we_link = 1'b1; n_wlink = slot_reg;
                end
                else if (!is_slot(n_rlink) && is_slot(pre_reg))
                begin
                    n_addr = pre_reg[AW-1:0]; n_we_link = 1'b1; n_wlink = NIL;
                    f_addr = q_reg[AW-1:0]; f_we = 1'b1;
                end
            end
            S_RM_FRONT_RD:
            begin
                n_addr = head_reg[AW-1:0];
            end
            S_RM_FRONT_WAIT:
            begin
                f_addr = head_reg[AW-1:0]; f_we = 1'b1;
            end
            S_PURGE_REF_RD:
            begin
                n_addr = s_reg[AW-1:0];
            end
            S_PURGE_NXT_WAIT:
            begin
                if (clr_reg || (cmp_payload ? n_rpay == rpay_reg : n_rkey == rkey_reg))
                begin
                    n_addr = pre_reg[AW-1:0]; n_we_link = 1'b1; n_wlink = n_rlink;
                    f_addr = q_reg[AW-1:0]; f_we = 1'b1;
                end
            end
            S_PURGE_ADV_RD:
            begin
                n_addr = s_reg[AW-1:0];
            end
            S_VIEW_RD:
            begin
                n_addr = cur_reg[AW-1:0];
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= NIL; cur_reg <= NIL; fhead_reg <= NIL; hw_reg <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next; cur_reg <= cur_next;
            fhead_reg <= fhead_next; hw_reg <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; pre_reg <= pre_next; s_reg <= s_next;
        slot_reg <= slot_next; req_reg <= req_next; key_reg <= key_next;
        pay_reg <= pay_next; pos_reg <= pos_next; cnt_reg <= cnt_next;
        st_reg <= st_next; found_reg <= found_next; clr_reg <= clr_next;
        rkey_reg <= rkey_next; rpay_reg <= rpay_next;
        if (state_reg == S_VIEW_WAIT)
        begin
            current_valid   <= is_slot(cur_reg);
            current_index   <= is_slot(cur_reg) ? 8'(cur_reg) : '0;
            current_key     <= is_slot(cur_reg) ? n_rkey : '0;
            current_payload <= is_slot(cur_reg) ? n_rpay : '0;
            status          <= st_reg;
            found_index     <= (st_reg == ST_OK) ? found_reg : '0;
        end
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
    end

    `ALL_ASSERT_IMP(a_one_side, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `ALL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ALL_ASSERT_NXT(a_take, clk, rst_n, in_valid && in_ready, state_reg == S_DISPATCH)
endmodule

### hdl/array_linked_list_free_list.sv
// Top level: linked list in a node store with free list, stream ports
// Requests are handled one at a time. Requests that meet an empty list or lack a cursor,
// purge of an empty list and unused codes go straight to reading the view; an insert that
// reuses a freed slot first reads the free list, one above the high-water mark does not.
// Insert at rear, remove rear, remove current, search, retrieve and clear walk the list
// node by node, and purge compares every pair of nodes, so it grows with the square of the
// list length. The node memories are single-port, one access per cycle with registered read
// data. One result per request; after the result transfer the block returns to idle before
// it takes the next request.
module array_linked_list_free_list import all_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: req_type[3:0], key[35:4], payload[99:36], position[107:100]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[2:0], found_index[10:3], current_valid[11], current_index[19:12],
    // current_key[51:20], current_payload[115:52]
    output logic [119:0] m_axis_tdata
);
    localparam int AW = $clog2(NODES);

    logic cmp_reg;
    logic [AW-1:0] n_addr, f_addr;
    logic n_we_data, n_we_link, f_we;
    logic [31:0] n_wkey, n_rkey, ck;
    logic [63:0] n_wpay, n_rpay, cp;
    logic [AW:0] n_wlink, n_rlink, f_wlink, f_rlink;
    logic [2:0] st;
    logic [7:0] fi, ci;
    logic cv;

    // hold the compare rule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cmp_reg <= 1'b0;
        else if (cfg_we) cmp_reg <= cfg_wdata;
    end

    all_ram #(.WIDTH(32), .DEPTH(NODES)) u_key (.clk, .we(n_we_data), .addr(n_addr),
        .wdata(n_wkey), .rdata(n_rkey));
    all_ram #(.WIDTH(64), .DEPTH(NODES)) u_pay (.clk, .we(n_we_data), .addr(n_addr),
        .wdata(n_wpay), .rdata(n_rpay));
    all_ram #(.WIDTH(AW+1), .DEPTH(NODES)) u_link (.clk, .we(n_we_link), .addr(n_addr),
        .wdata(n_wlink), .rdata(n_rlink));
    all_ram #(.WIDTH(AW+1), .DEPTH(NODES)) u_free (.clk, .we(f_we), .addr(f_addr),
        .wdata(f_wlink), .rdata(f_rlink));

    all_ctrl #(.NODES(NODES)) u_ctrl (
        .clk, .rst_n, .cmp_payload(cmp_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .req_type(s_axis_tdata[3:0]), .key(s_axis_tdata[35:4]),
        .payload(s_axis_tdata[99:36]), .position(s_axis_tdata[107:100]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .status(st), .found_index(fi), .current_valid(cv), .current_index(ci),
        .current_key(ck), .current_payload(cp),
        .n_addr, .n_we_data, .n_we_link, .n_wkey, .n_wpay, .n_wlink, .n_rkey,
        .n_rpay, .n_rlink, .f_addr, .f_we, .f_wlink, .f_rlink);

    assign m_axis_tdata = {4'b0, cp, ck, ci, cv, fi, st};
endmodule

### dv/testbench.sv
// Testbench for the linked-list block: directed table, then random traffic checked by a predictor
module testbench import all_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS = 256;
    localparam logic [8:0]  NIL   = 9'd256;
    localparam int          RANDOM_PER_PHASE = 250;

    typedef struct {
        logic [3:0]  req;
        logic [31:0] key;
        logic [63:0] payload;
        logic [7:0]  position;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  found_index;
        logic        current_valid;
        logic [7:0]  current_index;
        logic [31:0] current_key;
        logic [63:0] current_payload;
    } view_t;

    // One directed row; has_status marks a status typed in by hand
    typedef struct {
        request_t   rq;
        bit         has_status;
        logic [2:0] status;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;

    // Predictor state: node store, free links, list pointers
    logic [31:0] node_key [SLOTS];
    logic [63:0] node_pay [SLOTS];
    logic [8:0]  node_nxt [SLOTS];
    logic [8:0]  free_nxt [SLOTS];
    logic [8:0]  head_ptr, cur_ptr, free_ptr, top_ptr;
    bit          by_payload;
    int          list_len;

    view_t       pending_views[$];
    int          fails = 0;
    int          n_checked = 0;
    int          n_full = 0;
    int          n_found = 0;
    int          src_idle = 0;
    int          dst_idle = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    logic [31:0] key_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                  32'd1, 32'd2, 32'd3, 32'd77};
    logic [63:0] pay_pool [6] = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'd1, 64'd2, 64'd3,
                                  64'h8000_0000_0000_0000};

    array_linked_list_free_list u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Hard stop should the block hang
    initial
    begin
        #50_000_000;
        $display("** array_linked_list_free_list: FAILED **");
        $finish;
    end

    function automatic bit is_node(logic [8:0] s);
        return s < NIL;
    endfunction

    function automatic logic [8:0] take_slot();
        logic [8:0] s;
        if (is_node(free_ptr))
        begin
            s = free_ptr;
            free_ptr = free_nxt[s];
            return s;
        end
        s = is_node(top_ptr) ? top_ptr + 9'd1 : 9'd0;
        if (s >= NIL)
            return NIL;
        top_ptr = s;
        return s;
    endfunction

    function automatic void give_slot(logic [8:0] s);
        if (!is_node(s))
            return;
        free_nxt[s] = free_ptr;
        free_ptr = s;
    endfunction

    function automatic logic [2:0] drop_head();
        logic [8:0] nx;
        if (!is_node(head_ptr))
            return ST_EMPTY;
        nx = node_nxt[head_ptr];
        give_slot(head_ptr);
        head_ptr = nx;
        cur_ptr = nx;
        return ST_OK;
    endfunction

    function automatic bool_same(logic [8:0] a, logic [8:0] b);
        return by_payload ? node_pay[a] == node_pay[b] : node_key[a] == node_key[b];
    endfunction

    // Apply one request to the predictor and return the view it should produce
    function automatic view_t apply_request(request_t rq);
        view_t      v;
        logic [8:0] s, q, pre;
        bit         hit;
        v = '{default: '0};
        case (rq.req)
            REQ_INS_FRONT, REQ_INS_REAR:
            begin
                s = take_slot();
                if (!is_node(s))
                    v.status = ST_FULL;
                else
                begin
                    if (rq.req == REQ_INS_FRONT || !is_node(head_ptr))
                    begin
                        node_nxt[s] = head_ptr;
                        head_ptr = s;
                    end
                    else
                    begin
                        q = head_ptr;
                        for (int n = 0; n < SLOTS && is_node(node_nxt[q]); n++)
                            q = node_nxt[q];
                        node_nxt[s] = NIL;
                        node_nxt[q] = s;
                    end
                    node_key[s] = rq.key;
                    node_pay[s] = rq.payload;
                    cur_ptr = s;
                end
            end
            REQ_RM_FRONT:
                v.status = drop_head();
            REQ_RM_REAR:
            begin
                if (!is_node(head_ptr))
                    v.status = ST_EMPTY;
                else if (!is_node(node_nxt[head_ptr]))
                    v.status = drop_head();
                else
                begin
                    pre = head_ptr;
                    q = node_nxt[head_ptr];
                    for (int n = 0; n < SLOTS && is_node(node_nxt[q]); n++)
                    begin
                        pre = q;
                        q = node_nxt[q];
                    end
                    node_nxt[pre] = NIL;
                    give_slot(q);
                    cur_ptr = pre;
                end
            end
            REQ_RM_CUR:
            begin
                if (!is_node(head_ptr))
                    v.status = ST_EMPTY;
                else if (!is_node(cur_ptr))
                    v.status = ST_NOCUR;
                else if (cur_ptr == head_ptr)
                    v.status = drop_head();
                else
                begin
                    q = head_ptr;
                    for (int n = 0; n < SLOTS && is_node(q) && node_nxt[q] != cur_ptr; n++)
                        q = node_nxt[q];
                    if (!is_node(q) || node_nxt[q] != cur_ptr)
                        v.status = ST_NOCUR;
                    else
                    begin
                        node_nxt[q] = node_nxt[cur_ptr];
                        give_slot(cur_ptr);
                        cur_ptr = q;
                    end
                end
            end
            REQ_CLEAR:
            begin
                for (int n = 0; n < SLOTS && is_node(head_ptr); n++)
                    void'(drop_head());
                cur_ptr = NIL;
            end
            REQ_SEARCH:
            begin
                if (!is_node(head_ptr))
                    v.status = ST_EMPTY;
                else
                begin
                    v.status = ST_NOTFOUND;
                    q = head_ptr;
                    for (int n = 0; n < SLOTS && is_node(q); n++)
                    begin
                        hit = by_payload ? node_pay[q] == rq.payload : node_key[q] == rq.key;
                        if (hit)
                        begin
                            v.status = ST_OK;
                            v.found_index = q[7:0];
                            cur_ptr = q;
                            break;
                        end
                        q = node_nxt[q];
                    end
                end
            end
            REQ_RETRIEVE:
            begin
                if (!is_node(head_ptr))
                    v.status = ST_EMPTY;
                else
                begin
                    q = head_ptr;
                    for (int n = 0; n < rq.position && is_node(q); n++)
                        q = node_nxt[q];
                    if (!is_node(q))
                        v.status = ST_NOTFOUND;
                    else
                    begin
                        v.found_index = q[7:0];
                        cur_ptr = q;
                    end
                end
            end
            REQ_PURGE:
            begin
                s = head_ptr;
                for (int n = 0; n < SLOTS && is_node(s); n++)
                begin
                    pre = s;
                    for (int m = 0; m < SLOTS && is_node(node_nxt[pre]); m++)
                    begin
                        q = node_nxt[pre];
                        if (bool_same(s, q))
                        begin
                            node_nxt[pre] = node_nxt[q];
                            give_slot(q);
                        end
                        else
                            pre = q;
                    end
                    s = node_nxt[s];
                end
                cur_ptr = head_ptr;
            end
            default:
                ;
        endcase
        if (is_node(cur_ptr))
        begin
            v.current_valid   = 1'b1;
            v.current_index   = cur_ptr[7:0];
            v.current_key     = node_key[cur_ptr];
            v.current_payload = node_pay[cur_ptr];
        end
        list_len = 0;
        for (q = head_ptr; is_node(q) && list_len < SLOTS; q = node_nxt[q])
            list_len++;
        return v;
    endfunction

    // Offer one request; predict it once the transfer has happened
    task automatic send_request(request_t rq, bit has_status = 1'b0,
                                logic [2:0] typed_status = ST_OK);
        view_t v;
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rq.position, rq.payload, rq.key, rq.req};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        v = apply_request(rq);
        if (has_status)
            v.status = typed_status;
        pending_views.push_back(v);
    endtask

    task automatic drain_and_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_mode(bit mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        by_payload = mode;
    endtask

    function automatic request_t make_request();
        request_t rq;
        int       pick;
        rq.key      = $urandom_range(1) ? key_pool[$urandom_range(7)] : $urandom;
        rq.payload  = $urandom_range(1) ? pay_pool[$urandom_range(5)] : {$urandom, $urandom};
        rq.position = $urandom_range(9) < 7 ? 8'($urandom_range(list_len + 2))
                                            : 8'($urandom_range(255));
        pick = $urandom_range(99);
        // Keep lists short so walks and purges stay cheap
        if (list_len < 3 && pick >= 40)
            pick = pick % 30;
        else if (list_len > 24 && pick < 30)
            pick = 30 + pick;
        if (pick < 15)       rq.req = REQ_INS_FRONT;
        else if (pick < 30)  rq.req = REQ_INS_REAR;
        else if (pick < 38)  rq.req = REQ_RM_FRONT;
        else if (pick < 46)  rq.req = REQ_RM_REAR;
        else if (pick < 56)  rq.req = REQ_RM_CUR;
        else if (pick < 59)  rq.req = REQ_CLEAR;
        else if (pick < 74)  rq.req = REQ_SEARCH;
        else if (pick < 86)  rq.req = REQ_RETRIEVE;
        else if (pick < 95)  rq.req = list_len <= 40 ? REQ_PURGE : REQ_SEARCH;
        else                 rq.req = 4'($urandom_range(15, 9));
        return rq;
    endfunction

    // Fill the store to the brim, knock on it while full, then clear it
    task automatic fill_store();
        request_t rq;
        while (list_len < SLOTS)
        begin
            rq = make_request();
            rq.req = REQ_INS_FRONT;
            send_request(rq);
        end
        repeat (4)
        begin
            rq = make_request();
            rq.req = $urandom_range(1) ? REQ_INS_REAR : REQ_INS_FRONT;
            send_request(rq);
        end
        rq = make_request();
        rq.req = REQ_SEARCH;
        send_request(rq);
        rq.req = REQ_RETRIEVE;
        rq.position = 8'd255;
        send_request(rq);
        rq.req = REQ_RM_CUR;
        send_request(rq);
        rq.req = REQ_CLEAR;
        send_request(rq);
    endtask

    task automatic random_phase(int src, int dst, bit mode, bit squeeze);
        drain_and_idle();
        write_mode(mode);
        src_idle = src;
        dst_idle = dst;
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < RANDOM_PER_PHASE / 2; i++)
            send_request(make_request());
        fill_store();
        for (int i = 0; i < RANDOM_PER_PHASE / 2; i++)
            send_request(make_request());
    endtask

    // Receiver readiness, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        view_t v;
        logic [2:0]  st;
        logic [7:0]  fi, ci;
        logic        cv;
        logic [31:0] ck;
        logic [63:0] cp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {cp, ck, ci, cv, fi, st} = m_axis_tdata[115:0];
            if (pending_views.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $realtime, m_axis_tdata);
                fails++;
            end
            else
            begin
                v = pending_views.pop_front();
                n_checked++;
                if (st == ST_FULL) n_full++;
                if (st == ST_OK && v.found_index != 0) n_found++;
                if (st != v.status || fi != v.found_index || cv != v.current_valid ||
                    ci != v.current_index || ck != v.current_key || cp != v.current_payload)
                begin
                    $display("%0t: mismatch expected st=%0d fi=%0d cv=%0b ci=%0d ck=%h cp=%h",
                             $realtime, v.status, v.found_index, v.current_valid,
                             v.current_index, v.current_key, v.current_payload);
                    $display("%0t:          actual st=%0d fi=%0d cv=%0b ci=%0d ck=%h cp=%h",
                             $realtime, st, fi, cv, ci, ck, cp);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        row_t rows [23];
        rows = '{
            '{'{REQ_RM_FRONT,  32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY},
            '{'{REQ_RM_REAR,   32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY},
            '{'{REQ_RM_CUR,    32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY},
            '{'{REQ_SEARCH,    32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY},
            '{'{REQ_RETRIEVE,  32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY},
            '{'{REQ_PURGE,     32'h0, 64'h0, 8'd0}, 1'b1, ST_OK},
            '{'{REQ_CLEAR,     32'h0, 64'h0, 8'd0}, 1'b1, ST_OK},
            '{'{REQ_INS_FRONT, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 8'd0}, 1'b1, ST_OK},
            '{'{REQ_INS_REAR,  32'h8000_0000, 64'h0, 8'd0}, 1'b1, ST_OK},
            '{'{REQ_INS_REAR,  32'h0, 64'd1, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_INS_FRONT, 32'h7fff_ffff, 64'd5, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_RETRIEVE,  32'h0, 64'h0, 8'd255}, 1'b1, ST_NOTFOUND},
            '{'{REQ_RETRIEVE,  32'h0, 64'h0, 8'd2}, 1'b0, ST_OK},
            '{'{REQ_SEARCH,    32'h8000_0000, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_SEARCH,    32'd12345, 64'h0, 8'd0}, 1'b1, ST_NOTFOUND},
            '{'{REQ_PURGE,     32'h0, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_RM_CUR,    32'h0, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_RM_REAR,   32'h0, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{4'hf,          32'h0, 64'h0, 8'd0}, 1'b1, ST_OK},
            '{'{4'h9,          32'h0, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_RM_FRONT,  32'h0, 64'h0, 8'd0}, 1'b0, ST_OK},
            '{'{REQ_CLEAR,     32'h0, 64'h0, 8'd0}, 1'b1, ST_OK},
            '{'{REQ_RM_CUR,    32'h0, 64'h0, 8'd0}, 1'b1, ST_EMPTY}
        };
        head_ptr = NIL;
        cur_ptr = NIL;
        free_ptr = NIL;
        top_ptr = NIL;
        by_payload = 1'b0;
        list_len = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            node_key[i] = '0;
            node_pay[i] = '0;
            node_nxt[i] = '0;
            free_nxt[i] = '0;
        end

        // Hold reset, release on a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Explicitly write key mode, then run the directed table in key mode
        write_mode(1'b0);
        foreach (rows[i])
            send_request(rows[i].rq, rows[i].has_status, rows[i].status);

        random_phase(10, 81, 1'b1, 1'b0);
        random_phase(81, 10, 1'b0, 1'b0);
        random_phase(0, 0, 1'b1, 1'b1);

        drain_and_idle();
        repeat (50) @(posedge clk);
        $display("Checked %0d results over key and payload compare modes, all request codes",
                 n_checked);
        $display("including %0d store-full refusals and %0d hits away from slot 0", n_full,
                 n_found);
        if (fails == 0)
            $display("** array_linked_list_free_list: PASSED **");
        else
            $display("** array_linked_list_free_list: FAILED **");
        $finish;
    end

endmodule

### array_linked_list_free_list.f
+incdir+hdl
hdl/all_pkg.sv
hdl/all_ram.sv
hdl/all_ctrl.sv
hdl/array_linked_list_free_list.sv
dv/testbench.sv
